// File: design/bpcd_pkg.sv
package bpcd_pkg;

	localparam int COEFF_DEPTH_DEF = 4096;
	localparam int MAG_BITS_DEF    = 15;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_START  = 2'd1,
		CMD_SUPPLY = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CTX_SIG = 2'd0,
		CTX_SGN = 2'd1,
		CTX_REF = 2'd2
	} ctx_t;

endpackage

// File: design/bpcd_ram.sv
module bpcd_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = bpcd_pkg::COEFF_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the entry being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/bitplane_coefficient_decoder_top.sv
// Channel | Handshake             | Payload
// input   | in_valid / in_stall   | command, bit_plane, region_start, region_count,
//         |                       | decoded_bit, read_index
// output  | out_valid / out_stall | need_bit, bit_context, plane_done, coefficient,
//         |                       | protocol_error
//
// Every item gives one result and passes through idle and the result stage. On top of that a
// read passes through the reduction and read wait states, a stray bit or a significance bit of 1
// through nothing more, and a clear through the sweep state for each entry. Any other supplied
// bit and a start pass through the scan read and check states for each coefficient the scan
// examines and the scan read state per pass end; a start also passes through the reduction
// state. The scan is bound by the registered read of the coefficient memory. After reset, and
// for a clear item, a sweep writes zero to all COEFF_DEPTH entries, one per cycle, with
// in_stall high. Start and read indices at or above COEFF_DEPTH are reduced by one
// subtraction per cycle. The next item is taken while the previous result still waits under
// out_stall, and then waits itself in the result stage.
module bitplane_coefficient_decoder_top #(
	parameter int COEFF_DEPTH = bpcd_pkg::COEFF_DEPTH_DEF,
	parameter int MAG_BITS    = bpcd_pkg::MAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [3:0]         bit_plane,
	input  logic [11:0]        region_start,
	input  logic [12:0]        region_count,
	input  logic               decoded_bit,
	input  logic [11:0]        read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               need_bit,
	output logic [1:0]         bit_context,
	output logic               plane_done,
	output logic signed [15:0] coefficient,
	output logic               protocol_error
);

	import bpcd_pkg::*;

	localparam int AW      = $clog2(COEFF_DEPTH);
	localparam int CW      = $clog2(COEFF_DEPTH + 1);
	localparam int EW      = MAG_BITS + 3;
	localparam int SGN_BIT = MAG_BITS;
	localparam int SIG_BIT = MAG_BITS + 1;
	localparam int REF_BIT = MAG_BITS + 2;
	localparam logic [EW-1:0] SGN_F = EW'(1) << SGN_BIT;
	localparam logic [EW-1:0] SIG_F = EW'(1) << SIG_BIT;
	localparam logic [EW-1:0] REF_F = EW'(1) << REF_BIT;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_REDUCE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RD_WAIT,
		S_RESULT
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_addr_q;
	logic           clr_reply_q;
	cmd_t           cmd_q;
	logic [11:0]    red_q;
	logic [AW-1:0]  base_q;
	logic [AW-1:0]  addr_q;
	logic [CW-1:0]  pos_q;
	logic [CW-1:0]  end_q;
	logic [3:0]     plane_q;
	logic           second_q;
	ctx_t           ctx_q;
	logic           waiting_q;
	logic [EW-1:0]  ent_q;
	logic           done_q;
	logic [15:0]    coef_q;
	logic           perr_q;

	logic           out_valid_q;
	logic           need_bit_q;
	logic [1:0]     ctx_out_q;
	logic           plane_done_q;
	logic [15:0]    coefficient_q;
	logic           perr_out_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [EW-1:0]  wdata;
	logic [AW-1:0]  raddr;
	logic [EW-1:0]  rdata;

	cmd_t           cmd_in;
	logic           red_hi;
	logic [AW-1:0]  red_addr;
	logic [AW-1:0]  addr_inc;
	logic [CW-1:0]  pos_inc;
	logic [CW-1:0]  cnt_sat;
	logic [MAG_BITS-1:0] plane_mask;
	logic [EW-1:0]  bit_upd;
	logic [EW-1:0]  supply_ent;
	logic [31:0]    mag_ext;
	logic [31:0]    signed_val;
	logic           promote;

	bpcd_ram #(
		.WIDTH (EW),
		.DEPTH (COEFF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd_in   = cmd_t'(command);
	assign red_hi   = 32'(red_q) >= 32'(COEFF_DEPTH);
	assign red_addr = AW'(red_q);
	assign addr_inc = (addr_q == AW'(COEFF_DEPTH - 1)) ? '0 : addr_q + AW'(1);
	assign pos_inc  = pos_q + CW'(1);
	assign cnt_sat  = (32'(region_count) > 32'(COEFF_DEPTH)) ? CW'(COEFF_DEPTH)
		: CW'(region_count);

	// A plane at or above MAG_BITS shifts the one out and stores no magnitude bit.
	assign plane_mask = MAG_BITS'(1) << plane_q;
	assign bit_upd    = ent_q | (decoded_bit ? EW'(plane_mask) : '0);

	always_comb begin
		unique case (ctx_q)
			CTX_SGN: supply_ent = ent_q | SIG_F | (decoded_bit ? SGN_F : '0);
			default: supply_ent = bit_upd;
		endcase
	end

	assign promote    = second_q && !rdata[REF_BIT] && rdata[SIG_BIT];
	assign mag_ext    = 32'(rdata[MAG_BITS-1:0]);
	assign signed_val = rdata[SGN_BIT] ? (32'd0 - mag_ext) : mag_ext;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = supply_ent;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
			end
			S_IDLE: begin
				we = in_valid && (cmd_in == CMD_SUPPLY) && waiting_q;
			end
			S_SCAN_CHK: begin
				we    = promote;
				wdata = rdata ^ (SIG_F | REF_F);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign raddr = (state_q == S_REDUCE) ? red_addr : addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_addr_q   <= '0;
			clr_reply_q  <= 1'b0;
			cmd_q        <= CMD_CLEAR;
			base_q       <= '0;
			addr_q       <= '0;
			pos_q        <= '0;
			end_q        <= '0;
			plane_q      <= '0;
			second_q     <= 1'b0;
			ctx_q        <= CTX_SIG;
			waiting_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// The result stage reloads the output register itself.
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_addr_q == AW'(COEFF_DEPTH - 1)) begin
						state_q <= clr_reply_q ? S_RESULT : S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd_in;
						done_q <= 1'b0;
						coef_q <= '0;
						perr_q <= 1'b0;
						unique case (cmd_in)
							CMD_CLEAR: begin
								clr_addr_q  <= '0;
								clr_reply_q <= 1'b1;
								base_q      <= '0;
								addr_q      <= '0;
								pos_q       <= '0;
								end_q       <= '0;
								plane_q     <= '0;
								second_q    <= 1'b0;
								ctx_q       <= CTX_SIG;
								waiting_q   <= 1'b0;
								state_q     <= S_CLR;
							end
							CMD_START: begin
								red_q     <= region_start;
								end_q     <= cnt_sat;
								plane_q   <= bit_plane;
								pos_q     <= '0;
								second_q  <= 1'b0;
								ctx_q     <= CTX_SIG;
								waiting_q <= 1'b0;
								state_q   <= S_REDUCE;
							end
							CMD_SUPPLY: begin
								if (!waiting_q) begin
									perr_q  <= 1'b1;
									state_q <= S_RESULT;
								end else begin
									ent_q <= supply_ent;
									if (ctx_q == CTX_SIG && decoded_bit) begin
										ctx_q   <= CTX_SGN;
										state_q <= S_RESULT;
									end else begin
										pos_q   <= pos_inc;
										addr_q  <= addr_inc;
										state_q <= S_SCAN_RD;
									end
								end
							end
							CMD_READ: begin
								red_q   <= read_index;
								state_q <= S_REDUCE;
							end
						endcase
					end
				end
				S_REDUCE: begin
					if (red_hi) begin
						red_q <= red_q - 12'(COEFF_DEPTH);
					end else if (cmd_q == CMD_READ) begin
						state_q <= S_RD_WAIT;
					end else begin
						base_q  <= red_addr;
						addr_q  <= red_addr;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (pos_q >= end_q) begin
						pos_q  <= '0;
						addr_q <= base_q;
						if (!second_q) begin
							second_q <= 1'b1;
						end else begin
							second_q  <= 1'b0;
							waiting_q <= 1'b0;
							ctx_q     <= CTX_SIG;
							done_q    <= 1'b1;
							state_q   <= S_RESULT;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					// First pass stops on every coefficient not yet refining,
					// second pass on every refining one.
					if (second_q == rdata[REF_BIT]) begin
						ent_q     <= rdata;
						waiting_q <= 1'b1;
						ctx_q     <= second_q ? CTX_REF : CTX_SIG;
						state_q   <= S_RESULT;
					end else begin
						pos_q   <= pos_inc;
						addr_q  <= addr_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_RD_WAIT: begin
					coef_q  <= signed_val[15:0];
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						need_bit_q    <= waiting_q;
						ctx_out_q     <= waiting_q ? ctx_q : CTX_SIG;
						plane_done_q  <= done_q;
						coefficient_q <= coef_q;
						perr_out_q    <= perr_q;
						clr_reply_q   <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign need_bit       = need_bit_q;
	assign bit_context    = ctx_out_q;
	assign plane_done     = plane_done_q;
	assign coefficient    = coefficient_q;
	assign protocol_error = perr_out_q;

endmodule

// File: design/bpcd_checker.sv
module bpcd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              need_bit,
	input logic [1:0]        bit_context,
	input logic              plane_done,
	input logic signed [15:0] coefficient,
	input logic              protocol_error
);

	import bpcd_pkg::*;

	// A result held under stall keeps its coefficient, need_bit and plane_done.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coefficient)
			&& $stable(need_bit) && $stable(plane_done))
		else $error("result changed while stalled");

	a_idle_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !need_bit |-> bit_context == CTX_SIG)
		else $error("context reported while no bit is requested");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && plane_done |-> !need_bit)
		else $error("finished plane still requests a bit");

	a_stray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && protocol_error |-> !need_bit && !plane_done && coefficient == 16'sd0)
		else $error("stray bit result carries other information");

endmodule

bind bitplane_coefficient_decoder_top bpcd_checker u_bpcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.need_bit       (need_bit),
	.bit_context    (bit_context),
	.plane_done     (plane_done),
	.coefficient    (coefficient),
	.protocol_error (protocol_error)
);
